// ===== sv/bale_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_pkg - shared types and constants of the bounded array list engine
// Sizes of the list, operation and status codes, cell command bundle.
// ----------------------------------------------------------------------------
package bale_pkg;

    localparam int DEPTH       = 16;  // entries held in the cell row
    localparam int VALUE_WIDTH = 32;  // bits kept per entry

    localparam int PORT_VAL_W  = 32;  // value/data field width
    localparam int IDX_W       = 5;   // index field width
    localparam int POS_W       = 5;   // found_position field width
    localparam int CNTO_W      = 5;   // count field width
    localparam int CAP_W       = 5;   // capacity register width

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int SEL_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic             REG_CAPACITY = 1'b0;  // register index

    typedef logic [VALUE_WIDTH-1:0] t_val;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [CMP_W-1:0]       t_cmp;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_GET    = 3'd3,
        OP_FIND   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_OOB       = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Broadcast to every cell in the row.
    typedef struct packed {
        logic we_append;
        logic we_insert;
        logic we_remove;
        t_cmp idx;
        t_cnt count;
        t_val value;
    } t_cell_cmd;

    // Store a port value: truncate or sign-extend to the entry width.
    function automatic t_val to_stored(input logic [PORT_VAL_W-1:0] v);
        return VALUE_WIDTH'($signed(v));
    endfunction

    // Read an entry back: sign-extend or truncate to the port width.
    function automatic logic [PORT_VAL_W-1:0] from_stored(input t_val s);
        return PORT_VAL_W'($signed(s));
    endfunction

endpackage

// ===== sv/bounded_array_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_engine - ordered list of signed values in a cell row
// Append, insert, remove, get and find on a bounded list held in a row of
// shift cells, with an APB-style capacity register.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tuser: op; tdata: index, value
//  m_axis    out  tvalid/tready             tuser: status; tdata: data,
//                                           found_position, count
//  apb       in   psel/penable/pready       capacity at byte address 0
//
//  Cycles: one transfer per cycle; each item is resolved in the cycle it is
//  accepted and its result sits in the output register from the next cycle.
//  The cell row shifts all entries at once, so insert and remove cost
//  the same as append.
//  Reset: synchronous, empties the list and sets capacity to 16; entries
//  themselves are not cleared.
//  Stalls: s_axis_tready drops only while a result waits and m_axis_tready
//  is low.
// ----------------------------------------------------------------------------
module bounded_array_list_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [4:0] index, [36:5] value, rest zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] op
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] data, [36:32] found_position,
                                        // [41:37] count, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bale_pkg::*;

    // ---------------- configuration ----------------
    logic [CAP_W-1:0] r_capacity;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr && paddr[2] == REG_CAPACITY) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(r_capacity) : '0;

    // ---------------- input decode ----------------
    logic                  in_xfer;
    logic                  r_out_valid;
    t_op                   op;
    logic [IDX_W-1:0]      in_index;
    logic [PORT_VAL_W-1:0] in_value;
    t_val                  key;
    t_cmp                  idx_c;
    t_cmp                  cnt_c;
    t_cmp                  limit_c;
    t_cnt                  r_count;
    logic                  full;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign op       = t_op'(s_axis_tuser);
    assign in_index = s_axis_tdata[IDX_W-1:0];
    assign in_value = s_axis_tdata[IDX_W +: PORT_VAL_W];
    assign key      = to_stored(in_value);
    assign idx_c    = CMP_W'(in_index);
    assign cnt_c    = CMP_W'(r_count);

    // Effective limit is capacity clipped to the number of cells.
    assign limit_c = (CMP_W'(r_capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                          : CMP_W'(r_capacity);
    assign full    = (cnt_c >= limit_c);

    // ---------------- cell row ----------------
    t_cell_cmd                    cmd;
    logic [DEPTH-1:0][VALUE_WIDTH-1:0] entries;
    logic [DEPTH-1:0]             match;

    assign cmd.we_append = in_xfer && op == OP_APPEND && !full;
    assign cmd.we_insert = in_xfer && op == OP_INSERT && !full && idx_c <= cnt_c;
    assign cmd.we_remove = in_xfer && op == OP_REMOVE && idx_c < cnt_c;
    assign cmd.idx       = idx_c;
    assign cmd.count     = r_count;
    assign cmd.value     = key;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_val left_n;
        t_val right_n;

        // edge cells see the key and zero past the ends of the row
        assign left_n  = (g == 0) ? key : entries[(g == 0) ? 0 : g - 1];
        assign right_n = (g == DEPTH - 1) ? '0
                                          : entries[(g == DEPTH - 1) ? g : g + 1];

        bale_cell u_cell (
            .i_clk   (i_clk),
            .i_pos   (CNT_W'(g)),
            .i_cmd   (cmd),
            .i_left  (left_n),
            .i_right (right_n),
            .o_entry (entries[g]),
            .o_match (match[g])
        );
    end

    // ---------------- find and get ----------------
    logic             hit;
    logic [SEL_W-1:0] hit_pos;
    t_val             rd_entry;

    bale_scan u_scan (
        .i_match    (match),
        .i_entries  (entries),
        .i_sel      (in_index[SEL_W-1:0]),
        .o_hit      (hit),
        .o_hit_pos  (hit_pos),
        .o_rd_entry (rd_entry)
    );

    // ---------------- result ----------------
    t_status               res_status;
    logic [PORT_VAL_W-1:0] res_data;
    logic [POS_W-1:0]      res_found;
    t_cnt                  n_count;

    always_comb begin
        res_status = ST_OK;
        res_data   = '0;
        res_found  = '1;
        n_count    = r_count;
        case (op)
            OP_APPEND: begin
                if (full) begin
                    res_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (full) begin
                    res_status = ST_FULL;
                end else if (idx_c > cnt_c) begin
                    res_status = ST_OOB;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (idx_c >= cnt_c) begin
                    res_status = ST_OOB;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_GET: begin
                if (idx_c >= cnt_c) begin
                    res_status = ST_OOB;
                    res_data   = '1;
                end else begin
                    res_data = from_stored(rd_entry);
                end
            end
            OP_FIND: begin
                if (hit) begin
                    res_found = POS_W'(hit_pos);
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            default: begin
                // unused codes leave the list alone
            end
        endcase
    end

    // ---------------- output register ----------------
    t_status               r_status;
    logic [PORT_VAL_W-1:0] r_data;
    logic [POS_W-1:0]      r_found;
    logic [CNTO_W-1:0]     r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (in_xfer) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_status    <= res_status;
            r_data      <= res_data;
            r_found     <= res_found;
            r_out_count <= CNTO_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {6'b0, r_out_count, r_found, r_data};

    // ---------------- checks ----------------
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(DEPTH))
        else $error("entry count exceeds the cell row");

    a_append_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.we_append |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("append did not advance the count");

    a_remove_shrinks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.we_remove |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("remove did not drop the count");

    a_notfound_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_NOT_FOUND) |-> r_found == '1)
        else $error("not-found result carries a position");

    a_count_matches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_count == CNTO_W'(r_count))
        else $error("reported count differs from the list count");

endmodule

// ===== sv/bale_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_cell - one list slot
// Holds one entry; loads the new value, takes the left or right neighbor's
// entry on insert or remove, and compares its entry against the key.
// ----------------------------------------------------------------------------
module bale_cell (
    input  logic               i_clk,
    input  bale_pkg::t_cnt     i_pos,
    input  bale_pkg::t_cell_cmd i_cmd,
    input  bale_pkg::t_val     i_left,
    input  bale_pkg::t_val     i_right,
    output bale_pkg::t_val     o_entry,
    output logic               o_match
);
    import bale_pkg::*;

    t_val r_entry;
    t_val n_entry;
    t_cmp pos_c;
    t_cmp cnt_c;

    assign pos_c = CMP_W'(i_pos);
    assign cnt_c = CMP_W'(i_cmd.count);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.we_append && pos_c == cnt_c) begin
            n_entry = i_cmd.value;
        end else if (i_cmd.we_insert) begin
            if (pos_c == i_cmd.idx) begin
                n_entry = i_cmd.value;
            end else if (pos_c > i_cmd.idx && pos_c <= cnt_c) begin
                n_entry = i_left;
            end
        end else if (i_cmd.we_remove) begin
            if (pos_c >= i_cmd.idx && pos_c + CMP_W'(1) < cnt_c) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (pos_c < cnt_c) && (r_entry == i_cmd.value);

endmodule

// ===== sv/bale_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_scan - result selection over the cell row
// Priority-encode the lowest matching cell and select the entry to read.
// ----------------------------------------------------------------------------
module bale_scan (
    input  logic [bale_pkg::DEPTH-1:0]                        i_match,
    input  logic [bale_pkg::DEPTH-1:0][bale_pkg::VALUE_WIDTH-1:0] i_entries,
    input  logic [bale_pkg::SEL_W-1:0]                        i_sel,
    output logic                                              o_hit,
    output logic [bale_pkg::SEL_W-1:0]                        o_hit_pos,
    output bale_pkg::t_val                                    o_rd_entry
);
    import bale_pkg::*;

    always_comb begin
        o_hit     = 1'b0;
        o_hit_pos = '0;
        // walk down so the lowest match wins
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_hit     = 1'b1;
                o_hit_pos = SEL_W'(i);
            end
        end
    end

    assign o_rd_entry = i_entries[i_sel];

endmodule

// ===== dv/bounded_array_list_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_engine_tb - self-checking bench for the bounded list
// Drives append, insert, remove, get, find and unused op codes through the
// input stream, rewrites capacity over APB between phases, and scores every
// result transfer against a cycle-free bench model or a hand-written result.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_tb;
    import bale_pkg::*;

    localparam int NUM_ROWS       = 26;      // rows of the directed table
    localparam int NUM_PHASES     = 6;       // random phases
    localparam int REQ_PER_PHASE  = 205;     // random requests per phase
    localparam int LIMIT_CYCLES   = 200000;  // watchdog

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;  // -1 on the data field
    localparam logic [4:0]  NO_POS   = 5'h1F;          // -1 on found_position

    // op codes the block leaves undecoded
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam logic [31:0] VALUE_CORNERS [4] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF
    };
    localparam logic [4:0] PHASE_CAPS [NUM_PHASES] = '{
        5'd16, 5'd1, 5'd31, 5'd0, 5'd6, 5'd16
    };

    // One result transfer, split into its fields.
    typedef struct {
        logic [1:0]  status;
        logic [31:0] data;
        logic [4:0]  pos;
        logic [4:0]  count;
    } t_list_result;

    // One row of the directed table: a request or a capacity write.
    typedef struct {
        bit           is_cfg;
        bit           typed;   // use want instead of the bench model
        logic [2:0]   op;
        logic [4:0]   idx;
        logic [31:0]  val;     // capacity for a configuration row
        t_list_result want;
    } t_plan_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [4:0] index, [36:5] value, rest zero
    logic [2:0]  s_axis_tuser;   // [2:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [31:0] data, [36:32] found_position,
                                 // [41:37] count, rest zero
    logic [1:0]  m_axis_tuser;   // [1:0] status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Bench copy of the list and of the capacity register.
    logic [31:0] list_mem [DEPTH];
    int          list_len;
    logic [4:0]  cap_reg;

    t_list_result pending_results [$];   // results owed by the block, oldest first
    t_plan_row    directed_plan [NUM_ROWS];

    int send_idle_pct;
    int recv_stall_pct;
    int requests_sent;
    int results_checked;
    int cap_writes;
    int mismatch_count;
    int cycle_count;

    bounded_array_list_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------------
    // Request scored against the bench model.
    function automatic t_plan_row req(input logic [2:0] op, input logic [4:0] idx,
                                      input logic [31:0] val);
        t_plan_row r;
        r.is_cfg = 1'b0;
        r.typed  = 1'b0;
        r.op     = op;
        r.idx    = idx;
        r.val    = val;
        r.want   = '{2'd0, 32'd0, 5'd0, 5'd0};
        return r;
    endfunction

    // Request with its result written out by hand.
    function automatic t_plan_row chk(input logic [2:0] op, input logic [4:0] idx,
                                      input logic [31:0] val, input logic [1:0] st,
                                      input logic [31:0] data, input logic [4:0] pos,
                                      input logic [4:0] cnt);
        t_plan_row r;
        r       = req(op, idx, val);
        r.typed = 1'b1;
        r.want  = '{st, data, pos, cnt};
        return r;
    endfunction

    function automatic t_plan_row cap_write(input logic [4:0] cap);
        t_plan_row r;
        r        = req(OP_APPEND, 5'd0, 32'(cap));
        r.is_cfg = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Bench model: apply one request to the list copy, return its result
    // ------------------------------------------------------------------------
    function automatic t_list_result apply_list_op(input logic [2:0] op,
                                                   input logic [4:0] idx,
                                                   input logic [31:0] val);
        t_list_result r;
        int lim;
        int i;
        // capacity above the row size is clipped to the row size
        lim      = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
        r.status = ST_OK;
        r.data   = '0;
        r.pos    = NO_POS;
        case (op)
            OP_APPEND: begin
                if (list_len >= lim) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            OP_INSERT: begin
                // full wins over out of bounds
                if (list_len >= lim) begin
                    r.status = ST_FULL;
                end else if (int'(idx) > list_len) begin
                    r.status = ST_OOB;
                end else begin
                    for (i = list_len; i > int'(idx); i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[idx] = val;
                    list_len++;
                end
            end
            OP_REMOVE: begin
                if (int'(idx) >= list_len) begin
                    r.status = ST_OOB;
                end else begin
                    for (i = int'(idx); i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            OP_GET: begin
                if (int'(idx) >= list_len) begin
                    r.status = ST_OOB;
                    r.data   = ALL_ONES;
                end else begin
                    r.data = list_mem[idx];
                end
            end
            OP_FIND: begin
                r.status = ST_NOT_FOUND;
                // stop at the lowest match
                for (i = 0; i < list_len && r.pos == NO_POS; i++) begin
                    if (list_mem[i] == val) begin
                        r.status = ST_OK;
                        r.pos    = 5'(i);
                    end
                end
            end
            default: begin
            end
        endcase
        r.count = 5'(list_len);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input stream driver
    // ------------------------------------------------------------------------
    // Hold tvalid low for a random gap, present the request, wait for the
    // transfer, then log the result the block owes. tvalid is left high so
    // back-to-back transfers need no second assignment in the same step.
    task automatic send_request(input logic [2:0] op, input logic [4:0] idx,
                                input logic [31:0] val, input bit typed,
                                input t_list_result want);
        t_list_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, val, idx};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = apply_list_op(op, idx, val);
        pending_results.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    // Drop tvalid and wait until every owed result has come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // APB write of the capacity register: setup cycle, then access cycle.
    task automatic write_capacity(input logic [4:0] cap);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_CAPACITY);
        pwdata  <= 32'(cap);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_reg = cap;
        cap_writes++;
    endtask

    // Random request shaped from the current list: indexes mostly near the
    // valid range, values clustered so that find hits and duplicates occur.
    task automatic random_request();
        logic [2:0]   op;
        logic [4:0]   idx;
        logic [31:0]  val;
        int           pick;
        int           lim;
        t_list_result unused_want;
        unused_want = '{2'd0, 32'd0, 5'd0, 5'd0};
        lim  = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
        pick = $urandom_range(99);
        if (pick < 3)       op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        else if (pick < 30) op = OP_APPEND;
        else if (pick < 50) op = OP_INSERT;
        else if (pick < 72) op = OP_REMOVE;
        else if (pick < 86) op = OP_GET;
        else                op = OP_FIND;
        // when full, lean toward remove so the list keeps moving
        if ((op == OP_APPEND || op == OP_INSERT) && list_len >= lim && list_len > 0
                && $urandom_range(1) == 1)
            op = OP_REMOVE;
        if ($urandom_range(9) < 8) idx = 5'($urandom_range(list_len));
        else                       idx = 5'($urandom);
        case ($urandom_range(9)) inside
            [0:3]: val = 32'($urandom_range(8)) - 32'd4;
            [4:5]: val = VALUE_CORNERS[$urandom_range(3)];
            [6:7]: val = $urandom;
            default: begin
                if (list_len > 0) val = list_mem[$urandom_range(list_len - 1)];
                else              val = $urandom;
            end
        endcase
        send_request(op, idx, val, 1'b0, unused_want);
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at cycle %0d, result %0d: %s got %0h, expected %0h",
                 cycle_count, results_checked, field, got, want);
        mismatch_count++;
    endtask

    // Score each output transfer, then choose the next tready at random.
    always @(posedge i_clk) begin : result_monitor
        t_list_result oldest;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unrequested result", {30'd0, m_axis_tuser}, 32'd0);
            end else begin
                oldest = pending_results.pop_front();
                if (m_axis_tuser != oldest.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(oldest.status));
                if (m_axis_tdata[31:0] != oldest.data)
                    report_mismatch("data", m_axis_tdata[31:0], oldest.data);
                if (m_axis_tdata[36:32] != oldest.pos)
                    report_mismatch("found_position", 32'(m_axis_tdata[36:32]),
                                    32'(oldest.pos));
                if (m_axis_tdata[41:37] != oldest.count)
                    report_mismatch("count", 32'(m_axis_tdata[41:37]),
                                    32'(oldest.count));
            end
            results_checked++;
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int k;
        int ph;
        int n;
        s_axis_tvalid   <= 1'b0;
        s_axis_tdata    <= '0;
        s_axis_tuser    <= '0;
        m_axis_tready   <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_rst_n         <= 1'b0;
        list_len        = 0;
        cap_reg         = CAP_RESET;
        send_idle_pct   = 29;
        recv_stall_pct  = 85;
        requests_sent   = 0;
        results_checked = 0;
        cap_writes      = 0;
        mismatch_count  = 0;
        cycle_count     = 0;

        // Corners first: empty list, extremes of the value, shifts at both
        // ends, lowest duplicate for find, undecoded ops, capacity lowered
        // below the count, capacity zero, capacity above the row size.
        directed_plan = '{
            chk(OP_GET,     5'd0,  32'd0,         ST_OOB,       ALL_ONES, NO_POS, 5'd0),
            chk(OP_REMOVE,  5'd0,  32'd0,         ST_OOB,       32'd0,    NO_POS, 5'd0),
            chk(OP_FIND,    5'd0,  32'd0,         ST_NOT_FOUND, 32'd0,    NO_POS, 5'd0),
            chk(OP_INSERT,  5'd1,  32'd1,         ST_OOB,       32'd0,    NO_POS, 5'd0),
            chk(OP_APPEND,  5'd0,  32'h7FFF_FFFF, ST_OK,        32'd0,    NO_POS, 5'd1),
            chk(OP_APPEND,  5'd31, 32'h8000_0000, ST_OK,        32'd0,    NO_POS, 5'd2),
            chk(OP_INSERT,  5'd0,  ALL_ONES,      ST_OK,        32'd0,    NO_POS, 5'd3),
            chk(OP_INSERT,  5'd3,  32'd0,         ST_OK,        32'd0,    NO_POS, 5'd4),
            req(OP_INSERT,  5'd2,  32'd5),
            req(OP_APPEND,  5'd0,  32'd5),
            req(OP_FIND,    5'd0,  32'd5),
            req(OP_FIND,    5'd0,  32'h8000_0000),
            req(OP_GET,     5'd0,  32'd0),
            chk(OP_GET,     5'd31, 32'd0,         ST_OOB,       ALL_ONES, NO_POS, 5'd6),
            req(OP_REMOVE,  5'd0,  32'd0),
            req(OP_REMOVE,  5'd4,  32'd0),
            req(OP_UNUSED_LO, 5'd7, 32'hDEAD_BEEF),
            req(OP_UNUSED_HI, 5'd0, 32'd0),
            cap_write(5'd2),
            chk(OP_APPEND,  5'd0,  32'd9,         ST_FULL,      32'd0,    NO_POS, 5'd4),
            chk(OP_INSERT,  5'd31, 32'd9,         ST_FULL,      32'd0,    NO_POS, 5'd4),
            cap_write(5'd0),
            chk(OP_APPEND,  5'd0,  32'd9,         ST_FULL,      32'd0,    NO_POS, 5'd4),
            cap_write(5'd31),
            chk(OP_APPEND,  5'd0,  32'h8000_0001, ST_OK,        32'd0,    NO_POS, 5'd5),
            chk(OP_GET,     5'd30, 32'd0,         ST_OOB,       ALL_ONES, NO_POS, 5'd5)
        };

        // hold reset, then release it once
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < NUM_ROWS; k++) begin
            if (directed_plan[k].is_cfg)
                write_capacity(directed_plan[k].val[4:0]);
            else
                send_request(directed_plan[k].op, directed_plan[k].idx,
                             directed_plan[k].val, directed_plan[k].typed,
                             directed_plan[k].want);
        end

        // Random phases: a new capacity each, idle pattern every two phases
        // (slow receiver, then slow sender, then full rate).
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_capacity(PHASE_CAPS[ph]);
            case (ph / 2)
                0: begin
                    send_idle_pct  = 29;
                    recv_stall_pct = 85;
                end
                1: begin
                    send_idle_pct  = 85;
                    recv_stall_pct = 29;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (n = 0; n < REQ_PER_PHASE; n++)
                random_request();
        end

        // drain; the watchdog bounds this wait
        wait_idle();

        $display("Ran %0d list requests across %0d capacity writes; %0d results scored.",
                 requests_sent, cap_writes, results_checked);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
